FILE: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, off during reset
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion label failed");
// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion label failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/ltrb_pkg.sv
// package of the line terminated receive buffer: constants and cell control type
package ltrb_pkg;

  localparam int LINE_DEPTH_DEF = 64;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [1:0] MODE_CR   = 2'd0;
  localparam logic [1:0] MODE_LF   = 2'd1;
  localparam logic [1:0] MODE_CRLF = 2'd2;

  typedef struct packed {
    logic load;   // write the incoming byte into this cell
    logic shift;  // take the byte of the next cell up
  } cell_ctrl_t;

endpackage

FILE: rtl/ltrb_cell.sv
// one byte cell of the line store chain
module ltrb_cell
  import ltrb_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] load_data,
  input  logic [7:0] next_data,
  output logic [7:0] q
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    priority if (ctrl.shift) begin
      data_nxt = next_data;
    end else if (ctrl.load) begin
      data_nxt = load_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

FILE: rtl/line_terminated_receive_buffer.sv
// top level of the line terminated receive buffer
// usage:
//   input channel (in_valid/in_ready/in_rx_byte) takes one received byte per item.
//   bytes are stored in a row of LINE_DEPTH-1 byte cells until the terminator
//   set by the cfg port (cfg_we/cfg_wdata: 0 cr, 1 lf, 2 cr then lf) arrives.
//   result channel (out_valid/out_ready/out_*) gives the line bytes in order,
//   out_last on the final one; an empty line or an error gives a single item.
// output and drain:
//   a byte that causes one result shows it on the output in the cycle after accept.
//   a line drains one byte per cycle while the output slot is free, starting the
//   cycle after the terminator; the cell chain shifts toward cell 0 once per byte.
//   in_ready is low during the drain, so no new byte is taken until the line is out;
//   a plain data byte does not drop in_ready.
// reset:
//   synchronous active low; line empty, no cr pending, mode cr. cell contents
//   are not cleared, only bytes written in the current line are ever read.
// stall:
//   an output register holds the waiting item; while out_ready is low the drain
//   pauses with the cells held, and in_ready stays low until the slot frees.
module line_terminated_receive_buffer
  import ltrb_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic       out_error
);

`include "assert_macros.svh"

  localparam int NCELL  = LINE_DEPTH - 1;
  localparam int FILL_W = $clog2(LINE_DEPTH);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_DEPTH - 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  // control state
  logic              state_r,  state_nxt;
  logic [FILL_W-1:0] fill_r,   fill_nxt;   // bytes in line, counts down in drain
  logic              await_r,  await_nxt;  // cr seen in crlf mode
  logic [1:0]        mode_r,   mode_nxt;
  logic              oval_r,   oval_nxt;

  // output payload
  logic [7:0] obyte_r, obyte_nxt;
  logic       obv_r,   obv_nxt;
  logic       olast_r, olast_nxt;
  logic       oerr_r,  oerr_nxt;

  logic       slot_free;
  logic       accept;
  logic       do_store;   // byte goes into the line
  logic       do_end;     // terminator completes the line
  logic       do_err;     // bad terminator
  logic       drain_step;
  logic       cell_load;

  logic [7:0] cell_q [NCELL];

  assign slot_free  = !oval_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE) && slot_free;
  assign accept     = in_valid && in_ready;
  assign drain_step = (state_r == ST_DRAIN) && slot_free;

  // terminator decode for the current mode
  always_comb begin
    do_store  = 1'b0;
    do_end    = 1'b0;
    do_err    = 1'b0;
    await_nxt = await_r;
    unique case (mode_r)
      MODE_CR: begin
        await_nxt = 1'b0;
        if (in_rx_byte == CHAR_CR) do_end = 1'b1;
        else do_store = 1'b1;
      end
      MODE_LF: begin
        await_nxt = 1'b0;
        if (in_rx_byte == CHAR_LF) do_end = 1'b1;
        else if (in_rx_byte == CHAR_CR) do_err = 1'b1;
        else do_store = 1'b1;
      end
      MODE_CRLF: begin
        if (await_r) begin
          await_nxt = 1'b0;
          if (in_rx_byte == CHAR_LF) do_end = 1'b1;
          else do_err = 1'b1;
        end else if (in_rx_byte == CHAR_CR) begin
          await_nxt = 1'b1;
        end else begin
          do_store = 1'b1;
        end
      end
      default: begin
        // unused mode: byte dropped, state kept
      end
    endcase
    if (!accept) await_nxt = await_r;
  end

  // sequencing of the line and the output register
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    oval_nxt  = oval_r && !out_ready;
    obyte_nxt = obyte_r;
    obv_nxt   = obv_r;
    olast_nxt = olast_r;
    oerr_nxt  = oerr_r;
    cell_load = 1'b0;
    mode_nxt  = cfg_we ? cfg_wdata : mode_r;

    if (drain_step) begin
      oval_nxt  = 1'b1;
      obyte_nxt = cell_q[0];
      obv_nxt   = 1'b1;
      olast_nxt = (fill_r == FILL_W'(1));
      oerr_nxt  = 1'b0;
      fill_nxt  = fill_r - FILL_W'(1);
      if (fill_r == FILL_W'(1)) state_nxt = ST_IDLE;
    end else if (accept) begin
      priority if (do_err || (do_store && fill_r == FILL_MAX)) begin
        // bad terminator or full line: one error item, line starts over
        oval_nxt  = 1'b1;
        obyte_nxt = 8'h00;
        obv_nxt   = 1'b0;
        olast_nxt = 1'b1;
        oerr_nxt  = 1'b1;
        fill_nxt  = '0;
      end else if (do_store) begin
        cell_load = 1'b1;
        fill_nxt  = fill_r + FILL_W'(1);
      end else if (do_end && fill_r == '0) begin
        // empty line
        oval_nxt  = 1'b1;
        obyte_nxt = 8'h00;
        obv_nxt   = 1'b0;
        olast_nxt = 1'b1;
        oerr_nxt  = 1'b0;
      end else if (do_end) begin
        state_nxt = ST_DRAIN;
      end else begin
        // cr held in crlf mode, or unused mode
      end
    end
  end

  // the cell chain: load at the fill position, shift toward cell 0 on drain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] next_data;
    assign ctrl.load  = cell_load && (fill_r == FILL_W'(i));
    assign ctrl.shift = drain_step;
    if (i == NCELL - 1) begin : g_end
      assign next_data = 8'h00;
    end else begin : g_mid
      assign next_data = cell_q[i+1];
    end
    ltrb_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_data (in_rx_byte),
      .next_data (next_data),
      .q         (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      await_r <= 1'b0;
      mode_r  <= MODE_CR;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= (accept && (do_err || do_end)) ? fill_nxt : fill_nxt;
      await_r <= (accept && (do_err || (do_store && fill_r == FILL_MAX))) ? 1'b0 : await_nxt;
      mode_r  <= mode_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    obv_r   <= obv_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign out_valid      = oval_r;
  assign out_line_byte  = obyte_r;
  assign out_byte_valid = obv_r;
  assign out_last       = olast_r;
  assign out_error      = oerr_r;

  // checks
  `ASSERT_IMPL(a_drain_has_bytes, clk, rst_n, state_r == ST_DRAIN, fill_r != '0)
  `ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_MAX)
  `ASSERT_IMPL(a_err_shape, clk, rst_n, oval_r && oerr_r, !obv_r && olast_r)
  `ASSERT_NEXT(a_drain_done, clk, rst_n, drain_step && fill_r == FILL_W'(1),
               state_r == ST_IDLE && oval_r && olast_r)

endmodule

FILE: dv/line_result_checker.sv
// checker for the line terminated receive buffer: predicts line items and compares them
`timescale 1ns / 100ps

module line_result_checker
  import ltrb_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_line_byte,
  input  logic       out_byte_valid,
  input  logic       out_last,
  input  logic       out_error,
  output int         fail_count,
  output int         results_pending
);

  typedef struct packed {
    logic [7:0] line_byte;
    logic       byte_valid;
    logic       last;
    logic       error;
  } line_item_t;

  line_item_t  line_items_due[$];
  logic [7:0]  held_bytes [LINE_DEPTH];
  int unsigned held_count;
  logic        cr_pending;
  logic [1:0]  end_mode;
  int          mismatches = 0;

  assign fail_count = mismatches;

  task automatic drop_line();
    held_count = 0;
    cr_pending = 1'b0;
  endtask

  task automatic queue_error();
    line_items_due.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
    drop_line();
  endtask

  task automatic queue_line();
    if (held_count == 0) begin
      line_items_due.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
    end else begin
      for (int unsigned k = 0; k < held_count; k++) begin
        line_items_due.push_back('{held_bytes[k], 1'b1, (k + 1 == held_count), 1'b0});
      end
    end
    drop_line();
  endtask

  task automatic hold_byte(input logic [7:0] b);
    if (held_count >= LINE_DEPTH - 1) begin
      queue_error();
    end else begin
      held_bytes[held_count] = b;
      held_count++;
    end
  endtask

  // one received byte against the current terminator mode
  task automatic take_byte(input logic [7:0] b);
    case (end_mode)
      MODE_CR: begin
        cr_pending = 1'b0;
        if (b == CHAR_CR) queue_line();
        else hold_byte(b);
      end
      MODE_LF: begin
        cr_pending = 1'b0;
        if (b == CHAR_LF) queue_line();
        else if (b == CHAR_CR) queue_error();
        else hold_byte(b);
      end
      MODE_CRLF: begin
        if (cr_pending) begin
          cr_pending = 1'b0;
          if (b == CHAR_LF) queue_line();
          else queue_error();
        end else if (b == CHAR_CR) begin
          cr_pending = 1'b1;
        end else begin
          hold_byte(b);
        end
      end
      default: ;  // unused mode, byte ignored
    endcase
  endtask

  task automatic check_item();
    line_item_t got;
    line_item_t want;
    got = '{out_line_byte, out_byte_valid, out_last, out_error};
    if (line_items_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected item: byte %h valid %b last %b error %b",
                 got.line_byte, got.byte_valid, got.last, got.error);
    end else begin
      want = line_items_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte/valid/last/error %h %b %b %b got %h %b %b %b",
                   want.line_byte, want.byte_valid, want.last, want.error,
                   got.line_byte, got.byte_valid, got.last, got.error);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_items_due.delete();
      foreach (held_bytes[i]) held_bytes[i] = 8'h00;
      drop_line();
      end_mode = MODE_CR;
    end else begin
      if (out_valid && out_ready) check_item();
      if (cfg_we) end_mode = cfg_wdata;
      if (in_valid && in_ready) take_byte(in_rx_byte);
    end
    results_pending <= line_items_due.size();
  end

endmodule

FILE: dv/tb_line_terminated_receive_buffer.sv
// testbench top of the line terminated receive buffer: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_line_terminated_receive_buffer;
  import ltrb_pkg::*;

  // mode 3 is not a terminator setting, bytes are ignored there
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 24;
  localparam int PHASE_ITEMS  = 8;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_WAIT   = 70;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_line_byte;
  logic       out_byte_valid;
  logic       out_last;
  logic       out_error;

  int fail_count;
  int results_pending;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;  // set during the stretch with no idling on either side

  always #4 clk = ~clk;

  line_terminated_receive_buffer u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_line_byte (out_line_byte),
    .out_byte_valid(out_byte_valid),
    .out_last      (out_last),
    .out_error     (out_error)
  );

  line_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_byte  (out_line_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_error      (out_error),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  // receiver side: unless calm, drops ready about 7 percent of the time
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 7);
  end

  // watchdog: too many cycles without any item moving ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // one received byte; valid stays up until the item is taken
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // let every line item drain, then hold off for the extra clocks asked for before touching the mode
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_idle(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // payload byte that cannot end the line early in the given mode
  function automatic logic [7:0] data_byte(input logic [1:0] m);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_CR || (m == MODE_LF && b == CHAR_LF));
    return b;
  endfunction

  task automatic send_terminator(input logic [1:0] m);
    case (m)
      MODE_CR: send_byte(CHAR_CR);
      MODE_LF: send_byte(CHAR_LF);
      MODE_CRLF: begin
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
      end
      default: ;
    endcase
  endtask

  task automatic send_line(input logic [1:0] m, input int len);
    repeat (len) send_byte(data_byte(m));
    send_terminator(m);
  endtask

  // broken terminator for the mode: cr in lf mode, cr then a non-lf byte in crlf
  task automatic send_bad_end(input logic [1:0] m);
    logic [7:0] b;
    case (m)
      MODE_LF: send_byte(CHAR_CR);
      MODE_CRLF: begin
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
        send_byte(CHAR_CR);
        send_byte(b);
      end
      default: send_byte(CHAR_CR);
    endcase
  endtask

  initial begin
    logic [1:0] mode;
    int         phase;
    int         phase_start;
    int         pick;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= MODE_CR;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    out_ready  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // cr mode: byte extremes, then an empty line
    set_mode(MODE_CR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(CHAR_CR);

    // lf mode: a cr is an error, then a short line and an empty one
    set_mode(MODE_LF);
    send_byte(8'h55);
    send_byte(CHAR_CR);
    send_byte(8'hAA);
    send_byte(CHAR_LF);
    send_byte(CHAR_LF);

    // crlf mode: lone lf is data, good ending, bad ending consumes the byte
    set_mode(MODE_CRLF);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(CHAR_CR);

    // mode change with a cr pending: line is kept, the pending cr is dropped
    set_mode(MODE_CR);
    send_byte(8'h43);

    // unused mode ignores bytes and leaves the line alone
    set_mode(MODE_UNUSED);
    send_byte(8'h44);
    send_byte(CHAR_CR);
    set_mode(MODE_CR);
    send_byte(CHAR_CR);

    // longest line that fits, then one byte too many, with no idling on either side
    calm = 1'b1;
    send_line(MODE_CR, LINE_DEPTH_DEF - 1);
    repeat (LINE_DEPTH_DEF) send_byte(data_byte(MODE_CR));
    send_byte(CHAR_CR);
    calm = 1'b0;

    // random phases, each under its own mode; the first three walk the three terminator modes
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      mode = (phase < 3) ? 2'(phase) : 2'($urandom_range(0, 2));
      set_mode(mode);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 3) send_line(mode, $urandom_range(LINE_DEPTH_DEF - 4, LINE_DEPTH_DEF + 1));
        else if (pick < 78) send_line(mode, $urandom_range(0, 8));
        else if (pick < 88) send_bad_end(mode);
        else send_byte(8'($urandom_range(0, 255)));
      end
      phase++;
    end

    // drain, then allow for the longest line still in flight
    wait_idle(DRAIN_WAIT);
    if (fail_count == 0 && results_pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
